// ----- rtl/core/ils_pkg.sv -----
// ils_pkg: shared types and codes for the indexed list store.
// Used by indexed_list_store and ils_ram; depends on nothing.
`timescale 1ns / 1ps

package ils_pkg;

    // Operation carried by an input item
    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_REMOVE     = 2'd2,
        MODE_READ       = 2'd3
    } mode_t;

    // Status returned with every result item
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_PUT_HEAD,
        ST_READ,
        ST_FINISH
    } state_t;

    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 7;
    localparam int COUNT_OUT_W = 7;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 48;

endpackage

// ----- rtl/core/ils_ram.sv -----
// ils_ram: entry store for the indexed list store, one write and one read port.
// Read data is registered; depends on ils_pkg.
`timescale 1ns / 1ps

module ils_ram
    import ils_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [VALUE_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [VALUE_W-1:0] rd_data
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/indexed_list_store.sv -----
// indexed_list_store: ordered list of signed 32-bit entries with indexed remove/read.
// Top level; depends on ils_pkg and ils_ram.
`timescale 1ns / 1ps

// The block holds an ordered list of up to DEPTH signed 32-bit entries in a
// single-port-read, single-port-write RAM. Each input item carries one
// operation: push at the front, push at the back, remove at an index or read
// at an index; a negative position counts back from the end (-1 is the last
// entry). Every item returns exactly one result item with the value read
// (zero unless a read succeeds), a status and the entry count after the
// operation (low 7 bits). The block takes one item at a time: s_tready is
// high only while the sequencer is idle. Entries are moved one at a time
// through the RAM (read, then write back one slot over). Push back and
// rejected items go straight to ST_FINISH, a read through ST_READ; push
// front shifts each entry up one slot, then writes the head in ST_PUT_HEAD;
// remove shifts the entries behind the removed one down. A finished result
// waits in the output register while the next item is accepted; the
// sequencer stalls only if a second result is ready before the first left.
// The RAM needs no clearing: only entries below the count are ever read.

module indexed_list_store
    import ils_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // s_tdata, from bit 0: mode[1:0], value[33:2], position[40:34], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // m_tdata, from bit 0: read_value[31:0], status[33:32],
    // entry_count[40:34], zero pad
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > POSITION_W) ? CW : POSITION_W) + 1;

    // Input fields
    mode_t                  in_mode;
    logic [VALUE_W-1:0]     in_value;
    logic [POSITION_W-1:0]  in_position;

    assign in_mode     = mode_t'(s_tdata[1:0]);
    assign in_value    = s_tdata[VALUE_W+1:2];
    assign in_position = s_tdata[VALUE_W+POSITION_W+1:VALUE_W+2];

    // Registers
    state_t             state_reg,   state_next;
    logic [CW-1:0]      count_reg,   count_next;
    logic [AW-1:0]      idx_reg,     idx_next;
    mode_t              mode_reg,    mode_next;
    logic [VALUE_W-1:0] value_reg,   value_next;
    status_t            status_reg,  status_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // RAM port signals
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rd_data;

    // Position resolution against the current count
    logic signed [PW-1:0] pos_ext;
    logic signed [PW-1:0] cnt_ext;
    logic signed [PW-1:0] pos_norm;
    logic                 pos_ok;
    logic [AW-1:0]        slot;

    // Index helpers
    logic [CW:0]          idx_ext;
    logic [CW:0]          cnt_wide;
    logic [CW+6:0]        cnt_out;
    logic                 full;

    assign pos_ext  = {{(PW-POSITION_W){in_position[POSITION_W-1]}}, in_position};
    assign cnt_ext  = {{(PW-CW){1'b0}}, count_reg};
    assign pos_norm = in_position[POSITION_W-1] ? (pos_ext + cnt_ext) : pos_ext;
    assign pos_ok   = !pos_norm[PW-1] && (pos_norm < cnt_ext);
    assign slot     = pos_norm[AW-1:0];

    assign idx_ext  = {{(CW+1-AW){1'b0}}, idx_reg};
    assign cnt_wide = {1'b0, count_reg};
    assign cnt_out  = {7'd0, count_reg};
    assign full     = (count_reg >= CW'(DEPTH));

    ils_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        mode_reg    <= mode_next;
        value_reg   <= value_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        mode_next     = mode_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = rd_data;
        rd_en         = 1'b0;
        rd_addr       = idx_reg;
        s_tready      = 1'b0;

        // Drop the result once it is taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    mode_next   = in_mode;
                    value_next  = in_value;
                    status_next = STATUS_OK;
                    state_next  = ST_FINISH;
                    case (in_mode)
                        MODE_PUSH_FRONT, MODE_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else if (in_mode == MODE_PUSH_BACK)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                wr_data    = in_value;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                // Open a hole at the head by shifting up from the tail
                                idx_next   = count_reg[AW-1:0];
                                state_next = (count_reg == '0) ? ST_PUT_HEAD : ST_MOVE_RD;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else if (!pos_ok)
                            begin
                                status_next = STATUS_RANGE;
                            end
                            else
                            begin
                                idx_next = slot;
                                if (in_mode == MODE_READ)
                                begin
                                    state_next = ST_READ;
                                end
                                else if ({{(CW+1-AW){1'b0}}, slot} + 1'b1 < cnt_wide)
                                begin
                                    state_next = ST_MOVE_RD;
                                end
                                else
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end

            ST_MOVE_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = (mode_reg == MODE_PUSH_FRONT) ? (idx_reg - 1'b1)
                                                           : (idx_reg + 1'b1);
                state_next = ST_MOVE_WR;
            end

            ST_MOVE_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                if (mode_reg == MODE_PUSH_FRONT)
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = (idx_reg == AW'(1)) ? ST_PUT_HEAD : ST_MOVE_RD;
                end
                else
                begin
                    // Close the gap: advance toward the tail
                    idx_next = idx_reg + 1'b1;
                    if (idx_ext + (CW+1)'(2) < cnt_wide)
                    begin
                        state_next = ST_MOVE_RD;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_PUT_HEAD:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = value_reg;
                count_next = count_reg + 1'b1;
                state_next = ST_FINISH;
            end

            ST_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                // Hold here until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {
                        (M_DATA_W-VALUE_W-2-COUNT_OUT_W)'(0),
                        cnt_out[COUNT_OUT_W-1:0],
                        status_reg,
                        ((mode_reg == MODE_READ) && (status_reg == STATUS_OK))
                            ? rd_data : {VALUE_W{1'b0}}
                    };
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- tb/tb.sv -----
// tb: self-checking testbench for indexed_list_store, the bounded signed list
// with indexed remove and read. Depends on ils_pkg and the indexed_list_store RTL.
`timescale 1ns / 1ps

module tb;

    import ils_pkg::*;

    localparam int LIST_DEPTH   = 64;
    // Longest job is a push front onto a list one short of full, which moves
    // every entry held one slot up
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;

    // One result item, split into its fields
    typedef struct packed {
        logic [31:0] read_value;
        status_t     status;
        logic [6:0]  entry_count;
    } list_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // s_tdata, from bit 0: mode[1:0], value[33:2], position[40:34], zero pad
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // m_tdata, from bit 0: read_value[31:0], status[33:32], entry_count[40:34], zero pad
    logic [47:0] m_tdata;

    // Shadow copy of the list and the results still owed by the block
    logic [31:0]  list_shadow[$];
    list_result_t owed_results[$];

    int error_count     = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int deepest_list    = 0;
    int status_hits[4]  = '{0, 0, 0, 0};

    // Knobs shared by the stimulus tasks and the result receiver
    bit tx_gaps_on   = 1'b1;
    bit rx_stall_on  = 1'b1;
    int rx_hold_len  = 0;

    indexed_list_store #(.DEPTH(LIST_DEPTH)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    // Apply one accepted operation to the shadow list and return what the
    // block must answer. Positions below zero count back from the end; one
    // that stays negative, or lands at or past the count, is out of range.
    function automatic list_result_t apply_list_op(input logic [47:0] word);
        mode_t        op;
        logic [31:0]  value;
        int           pos;
        list_result_t res;
        op    = mode_t'(word[1:0]);
        value = word[33:2];
        pos   = $signed(word[40:34]);
        res.read_value = '0;
        res.status     = STATUS_OK;
        if (op == MODE_PUSH_FRONT || op == MODE_PUSH_BACK)
        begin
            if (list_shadow.size() >= LIST_DEPTH)
                res.status = STATUS_FULL;
            else if (op == MODE_PUSH_FRONT)
                list_shadow.push_front(value);
            else
                list_shadow.push_back(value);
        end
        else if (list_shadow.size() == 0)
        begin
            res.status = STATUS_EMPTY;
        end
        else
        begin
            if (pos < 0)
                pos += list_shadow.size();
            if (pos < 0 || pos >= list_shadow.size())
                res.status = STATUS_RANGE;
            else if (op == MODE_REMOVE)
                list_shadow.delete(pos);
            else
                res.read_value = list_shadow[pos];
        end
        res.entry_count = 7'(list_shadow.size());
        if (list_shadow.size() > deepest_list)
            deepest_list = list_shadow.size();
        return res;
    endfunction

    // Predict on every accepted input item, then check every accepted result
    // against the oldest prediction. Both use values from before the edge.
    always @(posedge clk)
    begin
        list_result_t want;
        list_result_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                owed_results.push_back(apply_list_op(s_tdata));
                items_accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                got.read_value  = m_tdata[31:0];
                got.status      = status_t'(m_tdata[33:32]);
                got.entry_count = m_tdata[40:34];
                if (owed_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result: expected none, got value %h %s %0d",
                             $time, got.read_value, got.status.name(), got.entry_count);
                end
                else
                begin
                    want = owed_results.pop_front();
                    results_checked++;
                    status_hits[want.status]++;
                    if (got.read_value !== want.read_value)
                    begin
                        error_count++;
                        $display("%0t: read_value mismatch: expected %h got %h",
                                 $time, want.read_value, got.read_value);
                    end
                    if (got.status !== want.status)
                    begin
                        error_count++;
                        $display("%0t: status mismatch: expected %s got %s",
                                 $time, want.status.name(), got.status.name());
                    end
                    if (got.entry_count !== want.entry_count)
                    begin
                        error_count++;
                        $display("%0t: entry_count mismatch: expected %0d got %0d",
                                 $time, want.entry_count, got.entry_count);
                    end
                end
            end
        end
    end

    // Result receiver: one assignment to m_tready per step. A requested
    // hold-off wins; otherwise stall in short random bursts when enabled.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_len > 0)
            begin
                n = rx_hold_len;
                rx_hold_len = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (rx_stall_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one item and hold it until the block takes it. Must be entered
    // at a rising edge. Leave tvalid high unless a gap follows.
    task automatic send_item(input mode_t op, input logic [31:0] value, input int position);
        s_tdata  <= {7'b0, 7'(position), value, op};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (tx_gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {16'($urandom), 32'($urandom)};
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Drop tvalid and wait until every owed result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (owed_results.size() != 0);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly valid indexes from either end, some just out of range, some raw
    function automatic int pick_position();
        int sz;
        int k;
        sz = list_shadow.size();
        k  = $urandom_range(0, 9);
        if (sz == 0 || k == 0)
            return $signed(7'($urandom));
        else if (k < 5)
            return $urandom_range(0, sz - 1);
        else if (k < 9)
            return -int'($urandom_range(1, sz));
        else if (k[0])
            return sz;
        else
            return -(sz + 1);
    endfunction

    // Remove and read with nothing held, at positions 0 and -1 and at the extremes
    task automatic test_empty_list();
        send_item(MODE_READ,   32'h1234_5678, 0);
        send_item(MODE_REMOVE, 32'hFFFF_FFFF, -64);
        send_item(MODE_READ,   32'h0,         63);
        send_item(MODE_REMOVE, 32'h0,         -1);
    endtask

    // Extreme values, every operation, negative indexes that land on the
    // first entry or stay negative, and indexes past the end
    task automatic test_edge_values();
        send_item(MODE_PUSH_BACK,  32'h7FFF_FFFF, 0);
        send_item(MODE_PUSH_FRONT, 32'h8000_0000, -64);
        send_item(MODE_PUSH_BACK,  32'hFFFF_FFFF, 63);
        send_item(MODE_PUSH_BACK,  32'h0000_0000, -1);
        send_item(MODE_READ,       32'hA5A5_A5A5, 0);
        send_item(MODE_READ,       32'h0,         -1);
        send_item(MODE_READ,       32'h0,         -4);
        send_item(MODE_READ,       32'h0,         -5);
        send_item(MODE_READ,       32'h0,         4);
        send_item(MODE_READ,       32'h0,         63);
        send_item(MODE_READ,       32'h0,         -64);
        send_item(MODE_REMOVE,     32'h0,         -4);
        send_item(MODE_REMOVE,     32'h0,         5);
        send_item(MODE_REMOVE,     32'h0,         -1);
        send_item(MODE_READ,       32'h0,         1);
        send_item(MODE_REMOVE,     32'h0,         0);
        send_item(MODE_REMOVE,     32'h0,         0);
    endtask

    // Fill to capacity with random content, push past full, then hit the
    // end slots of a full list
    task automatic test_fill_to_capacity();
        int room;
        wait_drained();
        room = LIST_DEPTH - list_shadow.size();
        repeat (room + 3)
            send_item($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, pick_value(), 0);
        send_item(MODE_READ,       32'h0, 63);
        send_item(MODE_READ,       32'h0, -64);
        send_item(MODE_REMOVE,     32'h0, -64);
        send_item(MODE_PUSH_FRONT, pick_value(), 0);
        send_item(MODE_PUSH_BACK,  pick_value(), 0);
        send_item(MODE_REMOVE,     32'h0, 63);
        send_item(MODE_READ,       32'h0, 62);
    endtask

    // Hold the receiver off while items keep coming, so the output register
    // fills and the block has to stall its input
    task automatic test_output_backpressure();
        wait_drained();
        tx_gaps_on  = 1'b0;
        rx_hold_len = 300;
        repeat (12)
            send_item($urandom_range(0, 2) == 0 ? MODE_READ : MODE_PUSH_FRONT,
                      pick_value(), pick_position());
        wait_drained();
        tx_gaps_on = 1'b1;
    endtask

    // Random operations in phases that grow, shrink or churn the list, with
    // idling switched on and off per phase
    task automatic test_random_mix(input int count);
        int bias;
        int r;
        mode_t op;
        bias = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                bias        = $urandom_range(0, 2);
                tx_gaps_on  = $urandom_range(0, 3) != 0;
                rx_stall_on = $urandom_range(0, 3) != 0;
            end
            r = $urandom_range(0, 99);
            case (bias)
                0:       op = r < 70 ? (r[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK)
                                     : (r < 85 ? MODE_REMOVE : MODE_READ);
                1:       op = r < 20 ? (r[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK)
                                     : (r < 80 ? MODE_REMOVE : MODE_READ);
                default: op = r < 35 ? (r[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK)
                                     : (r < 60 ? MODE_REMOVE : MODE_READ);
            endcase
            send_item(op, pick_value(), pick_position());
        end
    endtask

    // Closing stretch at full rate: no gaps, no stalls
    task automatic test_back_to_back(input int count);
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        repeat (count)
            send_item(mode_t'($urandom_range(0, 3)), pick_value(), pick_position());
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_edge_values();
        test_fill_to_capacity();
        test_output_backpressure();
        test_random_mix(420);
        test_back_to_back(70);

        // Let the last result out, then watch for stray results
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d items in, %0d results checked, list reached %0d of %0d entries",
                 items_accepted, results_checked, deepest_list, LIST_DEPTH);
        $display("tb: statuses seen: ok %0d, empty %0d, out of range %0d, full %0d",
                 status_hits[STATUS_OK], status_hits[STATUS_EMPTY],
                 status_hits[STATUS_RANGE], status_hits[STATUS_FULL]);
        if (error_count == 0 && owed_results.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/ils_pkg.sv
rtl/core/ils_ram.sv
rtl/core/indexed_list_store.sv
tb/tb.sv
